// File: rtl/ihs_pkg.sv
package ihs_pkg;

    localparam int FRAC_BITS  = 20;
    localparam int PT_W       = 6;
    localparam int VAL_W      = 32;
    localparam int DIAG_W     = 31;
    localparam int OPND_W     = 33;
    localparam int PROD_W     = 66;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID   = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [DIAG_W-1:0] lam;
        logic [DIAG_W-1:0] dt;
        logic [PT_W-1:0]   grid;
    } t_cfg;

    typedef enum logic [2:0] {
        A_ONE,
        A_LAM,
        A_CMP,
        A_DT,
        A_LOW
    } t_asel;

    typedef enum logic [2:0] {
        B_OLD,
        B_SRC,
        B_WORK,
        B_RBND,
        B_LBND,
        B_LDSUM
    } t_bsel;

    typedef struct packed {
        logic            capture;
        logic            acc_clr;
        logic            acc_en;
        t_asel           a_sel;
        t_bsel           b_sel;
        logic            sh21;
        logic            sub;
        logic [PT_W-1:0] addr_a;
        logic [PT_W-1:0] addr_b;
        logic [PT_W-1:0] row;
        logic            ld_wr;
        logic [PT_W-1:0] ld_addr;
        logic            row_wr;
        logic            div_init;
        logic            div_step;
        logic            div_wr;
        logic            out_ld;
        logic            is_right;
        logic            is_left;
    } t_cmd;

endpackage

// File: rtl/ihs_if.sv
interface ihs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] old_value;
    logic signed [31:0] source_now;
    logic signed [31:0] source_prev;
    logic signed [31:0] factor_lower;
    logic        [30:0] factor_diag;
    logic signed [31:0] boundary_value;
    logic               last_point;

    modport source (output valid, old_value, source_now, source_prev, factor_lower,
                    factor_diag, boundary_value, last_point, input ready);
    modport sink   (input valid, old_value, source_now, source_prev, factor_lower,
                    factor_diag, boundary_value, last_point, output ready);
endinterface

interface ihs_out_if;
    logic               valid;
    logic               ready;
    logic        [5:0]  point_index;
    logic signed [31:0] new_value;
    logic               last_result;

    modport source (output valid, point_index, new_value, last_result, input ready);
    modport sink   (input valid, point_index, new_value, last_result, output ready);
endinterface

// File: rtl/ihs_cfg.sv
module ihs_cfg import ihs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= 1'b0;
            r_cfg.lam  <= 31'd1048576;
            r_cfg.dt   <= 31'd1048576;
            r_cfg.grid <= 6'd2;
        end else if (i_we) begin
            case (i_idx)
                CFG_SCHEME: r_cfg.mode <= i_data[0];
                CFG_LAMBDA: r_cfg.lam  <= i_data;
                CFG_DT:     r_cfg.dt   <= i_data;
                CFG_GRID:   r_cfg.grid <= i_data[PT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/ihs_dp.sv
module ihs_dp import ihs_pkg::*; #(
    parameter int MAX_POINTS  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  t_cmd                     i_cmd,
    input  logic signed [VAL_W-1:0]  i_old_value,
    input  logic signed [VAL_W-1:0]  i_source_now,
    input  logic signed [VAL_W-1:0]  i_source_prev,
    input  logic signed [VAL_W-1:0]  i_factor_lower,
    input  logic        [DIAG_W-1:0] i_factor_diag,
    input  logic signed [VAL_W-1:0]  i_boundary_value,
    output logic        [PT_W-1:0]   o_point_index,
    output logic signed [VAL_W-1:0]  o_new_value,
    output logic                     o_last_result
);

    localparam int DPW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int NW  = DPW + FRAC_BITS;

    localparam logic signed [PROD_W-1:0] VMAX   = PROD_W'((64'd1 << (DPW - 1)) - 64'd1);
    localparam logic signed [PROD_W-1:0] VMIN   = ~VMAX;
    localparam logic signed [PROD_W-1:0] HALF20 = PROD_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [PROD_W-1:0] HALF21 = PROD_W'(64'd1 << FRAC_BITS);
    localparam logic signed [OPND_W-1:0] ONE_Q  = OPND_W'(64'd1 << FRAC_BITS);

    function automatic logic signed [DPW-1:0] sat(input logic signed [PROD_W-1:0] v);
        if (v > VMAX) begin
            return VMAX[DPW-1:0];
        end else if (v < VMIN) begin
            return VMIN[DPW-1:0];
        end
        return v[DPW-1:0];
    endfunction

    // stores
    logic signed [DPW-1:0]    r_old_store    [MAX_POINTS];
    logic signed [DPW-1:0]    r_source_store [MAX_POINTS];
    logic signed [DPW-1:0]    r_lower_store  [MAX_POINTS];
    logic        [DIAG_W-1:0] r_diag_store   [MAX_POINTS];
    logic signed [DPW-1:0]    r_work_store   [MAX_POINTS];

    logic signed [DPW-1:0]    r_old_rd;
    logic signed [DPW-1:0]    r_src_rd;
    logic signed [DPW-1:0]    r_low_rd;
    logic        [DIAG_W-1:0] r_diag_rd;
    logic signed [DPW-1:0]    r_work_rd;

    // captured item
    logic signed [DPW-1:0]    r_old;
    logic signed [DPW-1:0]    r_low;
    logic        [DIAG_W-1:0] r_diag;
    logic signed [DPW-1:0]    r_g;
    logic signed [OPND_W-1:0] r_fsum;
    logic signed [DPW-1:0]    r_lb;

    // MAC
    logic signed [OPND_W-1:0] opa;
    logic signed [OPND_W-1:0] opb;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] rq;
    logic signed [PROD_W-1:0] rsh;
    logic signed [DPW-1:0]    r_term;
    logic signed [DPW-1:0]    r_acc;
    logic signed [PROD_W-1:0] accsum;

    // divider
    logic        [NW-1:0]     r_num;
    logic        [DIAG_W-1:0] r_rem;
    logic        [DIAG_W-1:0] r_dv;
    logic                     r_zneg;
    logic                     r_zzero;
    logic                     r_dzero;
    logic        [DPW-1:0]    mag;
    logic        [NW-1:0]     num0;
    logic        [DIAG_W:0]   shl;
    logic                     ge;
    logic signed [PROD_W-1:0] qx;
    logic signed [PROD_W-1:0] qs;
    logic signed [DPW-1:0]    divres;

    logic signed [DPW-1:0]    fn;
    logic signed [DPW-1:0]    fp;
    logic                     ld_ok;

    logic        [PT_W-1:0]   r_out_idx;
    logic signed [DPW-1:0]    r_out_val;
    logic                     r_out_last;

    assign fn    = sat(PROD_W'(i_source_now));
    assign fp    = sat(PROD_W'(i_source_prev));
    assign ld_ok = ({1'b0, i_cmd.ld_addr} < (PT_W + 1)'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_old  <= sat(PROD_W'(i_old_value));
            r_low  <= sat(PROD_W'(i_factor_lower));
            r_diag <= i_factor_diag;
            r_g    <= sat(PROD_W'(i_boundary_value));
            r_fsum <= i_cfg.mode ? (OPND_W'(fn) + OPND_W'(fp)) : OPND_W'(fn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lb <= '0;
        end else if (i_cmd.ld_wr && i_cmd.ld_addr == '0) begin
            r_lb <= r_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_wr && ld_ok) begin
            r_old_store[i_cmd.ld_addr[AW-1:0]]    <= r_old;
            r_source_store[i_cmd.ld_addr[AW-1:0]] <= r_acc;
            r_lower_store[i_cmd.ld_addr[AW-1:0]]  <= r_low;
            r_diag_store[i_cmd.ld_addr[AW-1:0]]   <= r_diag;
        end
        if (i_cmd.row_wr) begin
            r_work_store[i_cmd.row[AW-1:0]] <= r_acc;
        end else if (i_cmd.div_wr) begin
            r_work_store[i_cmd.row[AW-1:0]] <= divres;
        end
        r_old_rd  <= r_old_store[i_cmd.addr_b[AW-1:0]];
        r_src_rd  <= r_source_store[i_cmd.addr_b[AW-1:0]];
        r_work_rd <= r_work_store[i_cmd.addr_b[AW-1:0]];
        r_diag_rd <= r_diag_store[i_cmd.addr_b[AW-1:0]];
        r_low_rd  <= r_lower_store[i_cmd.addr_a[AW-1:0]];
    end

    always_comb begin
        case (i_cmd.a_sel)
            A_ONE:   opa = ONE_Q;
            A_LAM:   opa = OPND_W'(i_cfg.lam);
            A_CMP:   opa = ONE_Q - OPND_W'(i_cfg.lam);
            A_DT:    opa = OPND_W'(i_cfg.dt);
            A_LOW:   opa = OPND_W'(r_low_rd);
            default: opa = ONE_Q;
        endcase
        case (i_cmd.b_sel)
            B_OLD:   opb = OPND_W'(r_old_rd);
            B_SRC:   opb = OPND_W'(r_src_rd);
            B_WORK:  opb = OPND_W'(r_work_rd);
            B_RBND:  opb = OPND_W'(r_g);
            B_LBND:  opb = OPND_W'(r_lb);
            B_LDSUM: opb = r_fsum;
            default: opb = '0;
        endcase
    end

    // rounding is floor((p + half) / 2^sh), i.e. an arithmetic shift
    always_comb begin
        rq     = r_prod + (i_cmd.sh21 ? HALF21 : HALF20);
        rsh    = i_cmd.sh21 ? (rq >>> (FRAC_BITS + 1)) : (rq >>> FRAC_BITS);
        accsum = PROD_W'(r_acc) + (i_cmd.sub ? -PROD_W'(r_term) : PROD_W'(r_term));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(opa) * PROD_W'(opb);
        r_term <= sat(rsh);
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= sat(accsum);
        end
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        mag    = r_work_rd[DPW-1] ? DPW'(-r_work_rd) : DPW'(r_work_rd);
        num0   = (NW'(mag) << FRAC_BITS) + NW'(r_diag_rd >> 1);
        shl    = {r_rem, r_num[NW-1]};
        ge     = (shl >= {1'b0, r_dv});
        qx     = PROD_W'(r_num);
        qs     = r_zneg ? -qx : qx;
        if (r_dzero) begin
            divres = r_zneg ? VMIN[DPW-1:0] : (r_zzero ? '0 : VMAX[DPW-1:0]);
        end else begin
            divres = sat(qs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_num   <= num0;
            r_rem   <= '0;
            r_dv    <= r_diag_rd;
            r_zneg  <= r_work_rd[DPW-1];
            r_zzero <= (r_work_rd == '0);
            r_dzero <= (r_diag_rd == '0);
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? DIAG_W'(shl - {1'b0, r_dv}) : shl[DIAG_W-1:0];
            r_num <= {r_num[NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_idx  <= i_cmd.row;
            r_out_last <= i_cmd.is_left;
            if (i_cmd.is_right) begin
                r_out_val <= r_g;
            end else if (i_cmd.is_left) begin
                r_out_val <= r_lb;
            end else begin
                r_out_val <= r_work_rd;
            end
        end
    end

    assign o_point_index = r_out_idx;
    assign o_new_value   = VAL_W'(r_out_val);
    assign o_last_result = r_out_last;

endmodule

// File: rtl/ihs_ctrl.sv
module ihs_ctrl import ihs_pkg::*; #(
    parameter int MAX_POINTS  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    input  logic i_in_last,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam int DPW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int NW  = DPW + FRAC_BITS;
    localparam int CW  = $clog2(NW);
    localparam logic [PT_W-1:0] TOP_ROW = PT_W'(MAX_POINTS - 1);

    typedef enum logic [14:0] {
        S_IDLE      = 15'h0001,
        S_OP_RD     = 15'h0002,
        S_OP_MUL    = 15'h0004,
        S_OP_RND    = 15'h0008,
        S_OP_ACC    = 15'h0010,
        S_LD_WR     = 15'h0020,
        S_ROW_START = 15'h0040,
        S_ROW_WR    = 15'h0080,
        S_DIV_RD    = 15'h0100,
        S_DIV_INIT  = 15'h0200,
        S_DIV_RUN   = 15'h0400,
        S_DIV_WR    = 15'h0800,
        S_OUT_RD    = 15'h1000,
        S_OUT_LD    = 15'h2000,
        S_OUT_SHOW  = 15'h4000
    } t_state;

    typedef enum logic [1:0] {
        PH_LOAD,
        PH_FWD,
        PH_BACK
    } t_phase;

    typedef struct packed {
        t_asel           a_sel;
        t_bsel           b_sel;
        logic            sh21;
        logic            sub;
        logic [PT_W-1:0] addr_a;
        logic [PT_W-1:0] addr_b;
    } t_op;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [PT_W-1:0] r_row, n_row;
    logic [2:0]      r_step, n_step;
    logic [PT_W-1:0] r_n, n_n;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [PT_W-1:0] r_load_cnt, n_load_cnt;
    logic            r_last, n_last;

    logic [PT_W-1:0] nclamp;
    t_op             op;
    logic            nx_found;
    logic [2:0]      nx_step;
    logic            st_found;
    logic [2:0]      st_step;

    function automatic logic step_en(input t_phase ph, input logic [2:0] s,
                                     input logic [PT_W-1:0] row, input logic [PT_W-1:0] n,
                                     input logic mode);
        logic e;
        e = 1'b0;
        if (ph == PH_FWD) begin
            case (s)
                3'd0:    e = 1'b1;
                3'd1:    e = mode;
                3'd2:    e = mode;
                3'd3:    e = 1'b1;
                3'd4:    e = (row == n - 1'b1);
                3'd5:    e = (row == PT_W'(1));
                3'd6:    e = (row > PT_W'(1));
                default: e = 1'b0;
            endcase
        end else if (ph == PH_BACK) begin
            e = (s <= 3'd1);
        end
        return e;
    endfunction

    // first enabled step at or after 'from'
    function automatic logic [3:0] first_en(input logic [3:0] from, input t_phase ph,
                                            input logic [PT_W-1:0] row,
                                            input logic [PT_W-1:0] n, input logic mode);
        logic       f;
        logic [2:0] s;
        f = 1'b0;
        s = '0;
        for (int k = 0; k < 7; k++) begin
            if (!f && 4'(k) >= from && step_en(ph, 3'(k), row, n, mode)) begin
                f = 1'b1;
                s = 3'(k);
            end
        end
        return {f, s};
    endfunction

    assign nclamp = (i_cfg.grid < PT_W'(2)) ? PT_W'(2) :
                    ((i_cfg.grid > TOP_ROW) ? TOP_ROW : i_cfg.grid);

    assign {nx_found, nx_step} = first_en({1'b0, r_step} + 4'd1, r_phase, r_row, r_n,
                                          i_cfg.mode);
    assign {st_found, st_step} = first_en(4'd0, r_phase, r_row, r_n, i_cfg.mode);

    always_comb begin
        op.a_sel  = A_ONE;
        op.b_sel  = B_OLD;
        op.sh21   = 1'b0;
        op.sub    = 1'b0;
        op.addr_a = r_row;
        op.addr_b = r_row;
        case (r_phase)
            PH_LOAD: begin
                op.a_sel = A_DT;
                op.b_sel = B_LDSUM;
                op.sh21  = i_cfg.mode;
            end
            PH_FWD: begin
                case (r_step)
                    3'd0: begin
                        op.a_sel = i_cfg.mode ? A_CMP : A_ONE;
                    end
                    3'd1: begin
                        op.a_sel  = A_LAM;
                        op.sh21   = 1'b1;
                        op.addr_b = r_row - 1'b1;
                    end
                    3'd2: begin
                        op.a_sel  = A_LAM;
                        op.sh21   = 1'b1;
                        op.addr_b = r_row + 1'b1;
                    end
                    3'd3: begin
                        op.b_sel = B_SRC;
                    end
                    3'd4: begin
                        op.a_sel = A_LAM;
                        op.b_sel = B_RBND;
                        op.sh21  = i_cfg.mode;
                    end
                    3'd5: begin
                        op.a_sel = A_LAM;
                        op.b_sel = B_LBND;
                        op.sh21  = i_cfg.mode;
                    end
                    default: begin
                        op.a_sel  = A_LOW;
                        op.b_sel  = B_WORK;
                        op.sub    = 1'b1;
                        op.addr_a = r_row - 1'b1;
                        op.addr_b = r_row - 1'b1;
                    end
                endcase
            end
            PH_BACK: begin
                op.b_sel = B_WORK;
                if (r_step != 3'd0) begin
                    op.a_sel  = A_LOW;
                    op.sub    = 1'b1;
                    op.addr_b = r_row + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_row      = r_row;
        n_step     = r_step;
        n_n        = r_n;
        n_cnt      = r_cnt;
        n_load_cnt = r_load_cnt;
        n_last     = r_last;

        o_cmd          = '0;
        o_cmd.a_sel    = op.a_sel;
        o_cmd.b_sel    = op.b_sel;
        o_cmd.sh21     = op.sh21;
        o_cmd.sub      = op.sub;
        o_cmd.addr_a   = op.addr_a;
        o_cmd.addr_b   = ((r_state == S_OP_RD) || (r_state == S_OP_MUL)) ? op.addr_b : r_row;
        o_cmd.row      = r_row;
        o_cmd.ld_addr  = r_load_cnt;
        o_cmd.is_right = (r_row == r_n);
        o_cmd.is_left  = (r_row == '0);

        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT_SHOW);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.acc_clr = 1'b1;
                    n_last        = i_in_last;
                    n_phase       = PH_LOAD;
                    n_state       = S_OP_MUL;
                end
            end
            S_OP_RD:  n_state = S_OP_MUL;
            S_OP_MUL: n_state = S_OP_RND;
            S_OP_RND: n_state = S_OP_ACC;
            S_OP_ACC: begin
                o_cmd.acc_en = 1'b1;
                if (r_phase == PH_LOAD) begin
                    n_state = S_LD_WR;
                end else if (nx_found) begin
                    n_step  = nx_step;
                    n_state = S_OP_RD;
                end else begin
                    n_state = S_ROW_WR;
                end
            end
            S_LD_WR: begin
                o_cmd.ld_wr = 1'b1;
                n_load_cnt  = r_load_cnt + 1'b1;
                if (r_last) begin
                    n_n     = nclamp;
                    n_row   = PT_W'(1);
                    n_phase = PH_FWD;
                    n_state = S_ROW_START;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROW_START: begin
                o_cmd.acc_clr = 1'b1;
                n_step        = st_step;
                n_state       = S_OP_RD;
            end
            S_ROW_WR: begin
                o_cmd.row_wr = 1'b1;
                if (r_phase == PH_FWD) begin
                    if (r_row == r_n - 1'b1) begin
                        n_row   = PT_W'(1);
                        n_state = S_DIV_RD;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_state = S_ROW_START;
                    end
                end else begin
                    if (r_row == PT_W'(1)) begin
                        n_row   = r_n;
                        n_state = S_OUT_RD;
                    end else begin
                        n_row   = r_row - 1'b1;
                        n_state = S_ROW_START;
                    end
                end
            end
            S_DIV_RD: n_state = S_DIV_INIT;
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    n_state = S_DIV_WR;
                end
            end
            S_DIV_WR: begin
                o_cmd.div_wr = 1'b1;
                if (r_row == r_n - 1'b1) begin
                    if (r_n == PT_W'(2)) begin
                        n_row   = r_n;
                        n_state = S_OUT_RD;
                    end else begin
                        n_row   = r_n - PT_W'(2);
                        n_phase = PH_BACK;
                        n_state = S_ROW_START;
                    end
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_DIV_RD;
                end
            end
            S_OUT_RD: n_state = S_OUT_LD;
            S_OUT_LD: begin
                o_cmd.out_ld = 1'b1;
                n_state      = S_OUT_SHOW;
            end
            S_OUT_SHOW: begin
                if (i_out_ready) begin
                    if (r_row == '0) begin
                        n_load_cnt = '0;
                        n_state    = S_IDLE;
                    end else begin
                        n_row   = r_row - 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_LOAD;
            r_row      <= '0;
            r_step     <= '0;
            r_n        <= PT_W'(2);
            r_cnt      <= '0;
            r_load_cnt <= '0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_row      <= n_row;
            r_step     <= n_step;
            r_n        <= n_n;
            r_cnt      <= n_cnt;
            r_load_cnt <= n_load_cnt;
            r_last     <= n_last;
        end
    end

endmodule

// File: rtl/implicit_heat_step_ldlt_solve_top.sv
// Channel   Dir  Beat contents
// i_in      in   old_value, source_now, source_prev, factor_lower, factor_diag,
//                boundary_value, last_point (one grid point, 0..N in order)
// o_out     out  point_index, new_value, last_result (points N down to 0)
// i_cfg_*   in   write enable, register index, 31-bit data
//
// Loading does one multiply per point, for the source term. Solve on one shared MAC:
// each term passes the read, multiply, round and accumulate states; k terms per
// forward row (k = 3..4 Euler, 5..6 Crank-Nicolson), a bit-serial divide per row,
// back-substitution rows, then each result beat is read, loaded and shown, held by
// any output stall. Synchronous active-low reset; the stores need no clearing. Input
// is taken only while idle (loading, between runs); a stalled beat holds the block.
module implicit_heat_step_ldlt_solve_top import ihs_pkg::*; #(
    parameter int MAX_POINTS  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ihs_in_if.sink                i_in,
    ihs_out_if.source             o_out
);

    t_cfg cfg;
    t_cmd cmd;
    logic in_ready;
    logic out_valid;

    ihs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ihs_ctrl #(
        .MAX_POINTS  (MAX_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_point),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    ihs_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .i_old_value      (i_in.old_value),
        .i_source_now     (i_in.source_now),
        .i_source_prev    (i_in.source_prev),
        .i_factor_lower   (i_in.factor_lower),
        .i_factor_diag    (i_in.factor_diag),
        .i_boundary_value (i_in.boundary_value),
        .o_point_index    (o_out.point_index),
        .o_new_value      (o_out.new_value),
        .o_last_result    (o_out.last_result)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

// File: rtl/ihs_chk.sv
module ihs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  i_out_index,
    input logic [31:0] i_out_value,
    input logic        i_out_last
);

    // no new point is taken while a result beat is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_index) && $stable(i_out_value) && $stable(i_out_last)))
        else $error("stalled result beat changed");

    a_last_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_index == 6'd0)))
        else $error("last_result does not match point 0");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (!i_out_valid && i_in_ready))
        else $error("block not idle after the final result");

endmodule

bind implicit_heat_step_ldlt_solve_top ihs_chk u_ihs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_index (o_out.point_index),
    .i_out_value (o_out.new_value),
    .i_out_last  (o_out.last_result)
);
